[rtl/core/crc_pkg.sv]
// Shared constants, types and helpers for the callsign route cache.
// No dependencies; imported by crc_match and callsign_route_cache_top.
`timescale 1ns / 1ps

package crc_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 24;
  localparam int unsigned DEF_CODE_CHARS  = 3;
  localparam int unsigned MAX_TABLE_DEPTH = 256;
  localparam int unsigned IDX_MAX_W       = $clog2(MAX_TABLE_DEPTH);

  localparam int unsigned OP_W      = 3;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned OUTCOME_W = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_NOTE     = 3'd0;
  localparam logic [OP_W-1:0] OP_REQUEST  = 3'd1;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  // Fetch outcomes; anything other than these two counts as settled no route
  localparam logic [OUTCOME_W-1:0] OUTCOME_TRANSIENT = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_SUCCESS   = 2'd1;

  typedef enum logic [1:0] {
    ST_EMPTY    = 2'd0,
    ST_PENDING  = 2'd1,
    ST_RESOLVED = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  // Result of the associative search, one per transaction
  typedef struct packed {
    logic                 match_found;
    logic [IDX_MAX_W-1:0] match_idx;
    logic                 match_pend;
    logic                 match_res;
    logic                 pend_found;
    logic [IDX_MAX_W-1:0] pend_idx;
    logic                 slot_hit;
  } match_t;

  // Keep bytes up to the first zero byte, at most nbytes of them.
  function automatic logic [KEY_W-1:0] cut_bytes(input logic [KEY_W-1:0] v,
                                                 input int unsigned nbytes);
    logic [KEY_W-1:0] r;
    logic             live;
    r    = '0;
    live = 1'b1;
    for (int unsigned i = 0; i < KEY_W / 8; i++) begin
      if (v[8*i +: 8] == 8'h00 || i >= nbytes) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*i +: 8] = v[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/crc_match.sv]
// Parallel key compare and priority search over the table status and keys.
// Depends on crc_pkg.
`timescale 1ns / 1ps

module crc_match #(
  parameter int unsigned TABLE_DEPTH = crc_pkg::DEF_TABLE_DEPTH
) (
  input  crc_pkg::status_e             tab_stat_i [TABLE_DEPTH],
  input  logic [crc_pkg::KEY_W-1:0]    tab_key_i  [TABLE_DEPTH],
  input  logic [crc_pkg::KEY_W-1:0]    key_i,
  input  logic [crc_pkg::SLOT_W-1:0]   slot_i,
  output crc_pkg::match_t              match_o
);
  import crc_pkg::*;

  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] pend_vec;

  always_comb begin
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      pend_vec[i] = (tab_stat_i[i] == ST_PENDING);
      hit_vec[i]  = (key_i != '0) && (tab_stat_i[i] != ST_EMPTY) &&
                    (tab_key_i[i] == key_i);
    end
  end

  // Scan downward so the lowest slot wins
  always_comb begin
    match_o = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        match_o.match_found = 1'b1;
        match_o.match_idx   = IDX_MAX_W'(i);
        match_o.match_pend  = pend_vec[i];
        match_o.match_res   = (tab_stat_i[i] == ST_RESOLVED);
      end
      if (pend_vec[i]) begin
        match_o.pend_found = 1'b1;
        match_o.pend_idx   = IDX_MAX_W'(i);
      end
      if ((32'(slot_i) == 32'(i)) && hit_vec[i] && pend_vec[i]) begin
        match_o.slot_hit = 1'b1;
      end
    end
  end

endmodule

[rtl/core/callsign_route_cache_top.sv]
// Top level of the callsign route cache: sequencer, status/key table and
// payload memory. Depends on crc_pkg and crc_match.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// -------  ---------  -----------------------  --------------------------------
// in       sink       in_valid_i / in_stall_o  opcode, callsign, position,
//                                              slot, outcome, origin/dest codes
// out      source     out_valid_o / out_stall_i hit, slot, callsign, position,
//                                              origin/dest codes
//
// The accept edge does the key compare and issues the payload memory
// read; the execute step, once no finished result is stalled, does the
// write-back and loads the output register. The payload memory is single-port.
// Reset clears status to empty and the cursor to zero at once; no sweep.
// While the output register is full and stalled the execute step waits,
// so one further transaction can be held behind a waiting result.

module callsign_route_cache_top #(
  parameter int unsigned TABLE_DEPTH = crc_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned CODE_CHARS  = crc_pkg::DEF_CODE_CHARS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [crc_pkg::OP_W-1:0]      opcode_i,
  input  logic [crc_pkg::KEY_W-1:0]     callsign_i,
  input  logic [crc_pkg::POS_W-1:0]     latitude_i,
  input  logic [crc_pkg::POS_W-1:0]     longitude_i,
  input  logic [crc_pkg::POS_W-1:0]     track_i,
  input  logic [crc_pkg::SLOT_W-1:0]    slot_i,
  input  logic [crc_pkg::OUTCOME_W-1:0] outcome_i,
  input  logic [8*CODE_CHARS-1:0]       origin_code_i,
  input  logic [8*CODE_CHARS-1:0]       dest_code_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [crc_pkg::SLOT_W-1:0]    out_slot_o,
  output logic [crc_pkg::KEY_W-1:0]     out_callsign_o,
  output logic [crc_pkg::POS_W-1:0]     out_latitude_o,
  output logic [crc_pkg::POS_W-1:0]     out_longitude_o,
  output logic [crc_pkg::POS_W-1:0]     out_track_o,
  output logic [8*CODE_CHARS-1:0]       out_origin_o,
  output logic [8*CODE_CHARS-1:0]       out_dest_o
);
  import crc_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CODE_W = 8 * CODE_CHARS;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // One payload memory word per slot
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  lat;
    logic [POS_W-1:0]  lon;
    logic [POS_W-1:0]  trk;
    logic [CODE_W-1:0] org;
    logic [CODE_W-1:0] dst;
  } entry_t;

  state_e state_q;

  // Status and keys live in flops for the parallel compare
  status_e          tab_stat_q [TABLE_DEPTH];
  logic [KEY_W-1:0] tab_key_q  [TABLE_DEPTH];
  logic [IDX_W-1:0] cursor_q;

  // Payload memory, registered read
  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;
  entry_t mem_wdata;
  logic   mem_we;

  // Captured transaction context
  logic [OP_W-1:0]      op_q;
  logic [KEY_W-1:0]     req_key_q;
  logic [POS_W-1:0]     lat_q, lon_q, trk_q;
  logic [OUTCOME_W-1:0] outcome_q;
  logic [CODE_W-1:0]    org_q, dst_q;
  match_t               mtc_q;
  logic [IDX_W-1:0]     addr_q;

  // Output register
  logic              out_valid_q;
  logic              hit_q;
  logic [SLOT_W-1:0] slot_q;
  logic [KEY_W-1:0]  ocall_q;
  logic [POS_W-1:0]  olat_q, olon_q, otrk_q;
  logic [CODE_W-1:0] oorg_q, odst_q;

  logic             in_acc;
  logic             commit;
  logic [KEY_W-1:0] key_in;
  logic [CODE_W-1:0] org_in, dst_in;
  logic [IDX_W-1:0] rd_addr;
  match_t           mtc;

  // Execute-step results and side effects
  logic              res_hit;
  logic [SLOT_W-1:0] res_slot;
  logic [KEY_W-1:0]  res_key;
  logic [POS_W-1:0]  res_lat, res_lon, res_trk;
  logic [CODE_W-1:0] res_org, res_dst;
  logic              st_we;
  status_e           st_wval;
  logic              key_we;
  logic              cur_adv;
  logic              clr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // execute step waits while a finished result is stalled
  assign commit     = (state_q == S_EXEC) && !(out_valid_q && out_stall_i);

  assign key_in = cut_bytes(callsign_i, KEY_W / 8);
  assign org_in = CODE_W'(cut_bytes(KEY_W'(origin_code_i), CODE_CHARS));
  assign dst_in = CODE_W'(cut_bytes(KEY_W'(dest_code_i), CODE_CHARS));

  crc_match #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_match (
    .tab_stat_i(tab_stat_q),
    .tab_key_i (tab_key_q),
    .key_i     (key_in),
    .slot_i    (slot_i),
    .match_o   (mtc)
  );

  // Slot that the transaction reads and may write back
  always_comb begin
    case (opcode_i)
      OP_NOTE:     rd_addr = mtc.match_found ? mtc.match_idx[IDX_W-1:0] : cursor_q;
      OP_REQUEST:  rd_addr = mtc.pend_idx[IDX_W-1:0];
      OP_COMPLETE: rd_addr = IDX_W'(slot_i);
      OP_LOOKUP:   rd_addr = mtc.match_idx[IDX_W-1:0];
      default:     rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= opcode_i;
      req_key_q <= key_in;
      lat_q     <= latitude_i;
      lon_q     <= longitude_i;
      trk_q     <= track_i;
      outcome_q <= outcome_i;
      org_q     <= org_in;
      dst_q     <= dst_in;
      mtc_q     <= mtc;
      addr_q    <= rd_addr;
    end
  end

  // Payload memory: read on accept, write back on commit
  always_ff @(posedge clk_i) begin
    if (commit && mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    if (in_acc) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Execute step: merge read data with the transaction
  always_comb begin
    res_hit   = 1'b0;
    res_slot  = '0;
    res_key   = '0;
    res_lat   = '0;
    res_lon   = '0;
    res_trk   = '0;
    res_org   = '0;
    res_dst   = '0;
    mem_we    = 1'b0;
    mem_wdata = rdata_q;
    st_we     = 1'b0;
    st_wval   = ST_EMPTY;
    key_we    = 1'b0;
    cur_adv   = 1'b0;
    clr       = 1'b0;
    case (op_q)
      OP_NOTE: begin
        if (req_key_q != '0) begin
          res_slot = SLOT_W'(addr_q);
          if (mtc_q.match_found) begin
            res_hit = 1'b1;
            if (mtc_q.match_pend) begin
              mem_we        = 1'b1;
              mem_wdata.lat = lat_q;
              mem_wdata.lon = lon_q;
              mem_wdata.trk = trk_q;
            end
          end else begin
            // miss: take over the slot under the cursor
            mem_we    = 1'b1;
            mem_wdata = '{key: req_key_q, lat: lat_q, lon: lon_q, trk: trk_q,
                          org: '0, dst: '0};
            st_we     = 1'b1;
            st_wval   = ST_PENDING;
            key_we    = 1'b1;
            cur_adv   = 1'b1;
          end
        end
      end
      OP_REQUEST: begin
        if (mtc_q.pend_found) begin
          res_hit  = 1'b1;
          res_slot = SLOT_W'(addr_q);
          res_key  = rdata_q.key;
          res_lat  = rdata_q.lat;
          res_lon  = rdata_q.lon;
          res_trk  = rdata_q.trk;
        end
      end
      OP_COMPLETE: begin
        if (mtc_q.slot_hit) begin
          res_slot = SLOT_W'(addr_q);
          if (outcome_q != OUTCOME_TRANSIENT) begin
            res_hit = 1'b1;
            st_we   = 1'b1;
            if (outcome_q == OUTCOME_SUCCESS && org_q != '0 && dst_q != '0) begin
              mem_we        = 1'b1;
              mem_wdata.org = org_q;
              mem_wdata.dst = dst_q;
              st_wval       = ST_RESOLVED;
            end else begin
              st_wval = ST_NONE;
            end
          end
        end
      end
      OP_LOOKUP: begin
        if (mtc_q.match_found && mtc_q.match_res) begin
          res_hit  = 1'b1;
          res_slot = SLOT_W'(addr_q);
          res_org  = rdata_q.org;
          res_dst  = rdata_q.dst;
        end
      end
      OP_CLEAR: begin
        clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Status table and replacement cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
        tab_stat_q[i] <= ST_EMPTY;
      end
      cursor_q <= '0;
    end else if (commit) begin
      if (clr) begin
        for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
          tab_stat_q[i] <= ST_EMPTY;
        end
        cursor_q <= '0;
      end else begin
        if (st_we) begin
          tab_stat_q[addr_q] <= st_wval;
        end
        if (cur_adv) begin
          cursor_q <= (cursor_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : cursor_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && key_we) begin
      tab_key_q[addr_q] <= req_key_q;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      slot_q      <= '0;
      ocall_q     <= '0;
      olat_q      <= '0;
      olon_q      <= '0;
      otrk_q      <= '0;
      oorg_q      <= '0;
      odst_q      <= '0;
    end else begin
      // a new result replaces one that leaves at the same edge
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_q     <= S_IDLE;
            hit_q       <= res_hit;
            slot_q      <= res_slot;
            ocall_q     <= res_key;
            olat_q      <= res_lat;
            olon_q      <= res_lon;
            otrk_q      <= res_trk;
            oorg_q      <= res_org;
            odst_q      <= res_dst;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign out_slot_o      = slot_q;
  assign out_callsign_o  = ocall_q;
  assign out_latitude_o  = olat_q;
  assign out_longitude_o = olon_q;
  assign out_track_o     = otrk_q;
  assign out_origin_o    = oorg_q;
  assign out_dest_o      = odst_q;

  // An accepted transaction always moves to execute and blocks the input
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EXEC) && in_stall_o)
    else $error("accepted transaction did not enter execute");

  // A request hit reports a slot that really is pending
  a_req_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_q == OP_REQUEST && res_hit) |-> (tab_stat_q[addr_q] == ST_PENDING))
    else $error("request hit on a slot that is not pending");

  // After a clear nothing matches and nothing is pending
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_q == OP_CLEAR) |=> (!mtc.pend_found && !mtc.match_found))
    else $error("table not empty after clear");

  // A note miss leaves its key pending in the slot it took
  a_note_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && key_we) |=> (tab_stat_q[$past(addr_q)] == ST_PENDING) &&
                           (tab_key_q[$past(addr_q)] == $past(req_key_q)))
    else $error("note miss did not install the key");

endmodule
